@@ src/mav_pkg.sv @@
`timescale 1ns / 1ps

package mav_pkg;

  // Width and reset value of the window length register
  localparam int unsigned LENGTH_BITS = 5;
  localparam logic [LENGTH_BITS-1:0] LENGTH_RESET = LENGTH_BITS'(8);

  // Back-end sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_DIVIDE,
    ST_EMIT
  } back_state_t;

endpackage

@@ src/mav_sample_if.sv @@
`timescale 1ns / 1ps

interface mav_sample_if #(
  parameter int unsigned SAMPLE_BITS = 12
);
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

@@ src/mav_average_if.sv @@
`timescale 1ns / 1ps

interface mav_average_if #(
  parameter int unsigned SAMPLE_BITS = 12
);
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] average;

  modport source (output valid, output average, input ready);
  modport sink   (input valid, input average, output ready);
endinterface

@@ src/mav_queue.sv @@
`timescale 1ns / 1ps

module mav_queue
  import mav_pkg::*;
#(
  parameter int unsigned SAMPLE_BITS = 12
) (
  input  logic         clk,
  input  logic         rst_n,
  mav_sample_if.sink   in_ch,
  mav_sample_if.source q_ch
);

  localparam int unsigned DEPTH = 2;
  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [SAMPLE_BITS-1:0] slot_r [DEPTH];
  logic [PTR_W-1:0]       wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]       rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]       count_r, count_nxt;
  logic                   push, pop;

  // Take a beat whenever a slot is free; offer the oldest held beat
  assign in_ch.ready = (count_r != CNT_W'(DEPTH));
  assign q_ch.valid  = (count_r != '0);
  assign q_ch.sample = slot_r[rd_ptr_r];

  assign push = in_ch.valid && in_ch.ready;
  assign pop  = q_ch.valid && q_ch.ready;

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store incoming samples
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= in_ch.sample;
    end
  end

endmodule

@@ src/mav_div.sv @@
`timescale 1ns / 1ps

module mav_div
  import mav_pkg::*;
#(
  parameter int unsigned NUM_BITS = 16,
  parameter int unsigned DEN_BITS = 5
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [NUM_BITS-1:0] dividend,
  input  logic [DEN_BITS-1:0] divisor,
  output logic                done,
  output logic [NUM_BITS-1:0] quotient
);

  localparam int unsigned CNT_W = $clog2(NUM_BITS + 1);

  logic [NUM_BITS-1:0] quo_r, quo_nxt;
  logic [DEN_BITS-1:0] rem_r, rem_nxt;
  logic [DEN_BITS-1:0] den_r;
  logic [CNT_W-1:0]    cnt_r;
  logic                busy_r;
  logic                done_r;
  logic [DEN_BITS:0]   trial;
  logic                fits;

  // One restoring step: shift in the next dividend bit, subtract if it fits
  always_comb begin
    trial   = {rem_r, quo_r[NUM_BITS-1]};
    fits    = (trial >= {1'b0, den_r});
    rem_nxt = fits ? DEN_BITS'(trial - {1'b0, den_r}) : DEN_BITS'(trial);
    quo_nxt = {quo_r[NUM_BITS-2:0], fits};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(NUM_BITS);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Load operands, then iterate one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      den_r <= divisor;
    end else if (busy_r) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

@@ src/mav_back.sv @@
`timescale 1ns / 1ps

module mav_back
  import mav_pkg::*;
#(
  parameter int unsigned WINDOW_MAX  = 16,
  parameter int unsigned SAMPLE_BITS = 12
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic [LENGTH_BITS-1:0] cfg_data,
  mav_sample_if.sink             q_ch,
  mav_average_if.source          out_ch
);

  localparam int unsigned SUM_BITS = SAMPLE_BITS + $clog2(WINDOW_MAX);
  localparam int unsigned LEN_W    = $clog2(WINDOW_MAX + 1);
  localparam int unsigned POS_W    = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;

  back_state_t            state_r, state_nxt;
  logic [LENGTH_BITS-1:0] len_r;
  logic [LEN_W-1:0]       act_len;
  logic [SUM_BITS-1:0]    sum_r, sum_nxt;
  logic [POS_W-1:0]       pos_r, pos_use, pos_nxt;
  logic [LEN_W-1:0]       pos_inc;
  logic [WINDOW_MAX-1:0]  valid_r;
  logic [SAMPLE_BITS-1:0] mem [WINDOW_MAX];
  logic [SAMPLE_BITS-1:0] rd_data_r;
  logic [SAMPLE_BITS-1:0] sample_r;
  logic [SAMPLE_BITS-1:0] oldest;
  logic [SAMPLE_BITS-1:0] avg_r;
  logic                   out_valid_r;
  logic                   take, update, load_out;
  logic                   div_done;
  logic [SUM_BITS-1:0]    div_quo;

  // Map the length register onto 1..WINDOW_MAX
  always_comb begin
    if (len_r == '0) begin
      act_len = LEN_W'(1);
    end else if (32'(len_r) > 32'(WINDOW_MAX)) begin
      act_len = LEN_W'(WINDOW_MAX);
    end else begin
      act_len = LEN_W'(len_r);
    end
  end

  // Wrap a stray position, then advance around the active window
  always_comb begin
    pos_use = (LEN_W'(pos_r) >= act_len) ? '0 : pos_r;
    pos_inc = LEN_W'(pos_use) + LEN_W'(1);
    pos_nxt = (pos_inc >= act_len) ? '0 : POS_W'(pos_inc);
    oldest  = valid_r[pos_use] ? rd_data_r : '0;
    sum_nxt = (sum_r - SUM_BITS'(oldest)) + SUM_BITS'(sample_r);
  end

  // Sequencer: take a beat, update the window, divide, hand off the result
  always_comb begin
    state_nxt  = state_r;
    take       = 1'b0;
    update     = 1'b0;
    load_out   = 1'b0;
    q_ch.ready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        q_ch.ready = 1'b1;
        if (q_ch.valid) begin
          take      = 1'b1;
          state_nxt = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        update    = 1'b1;
        state_nxt = ST_DIVIDE;
      end
      ST_DIVIDE: begin
        if (div_done) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!out_valid_r || out_ch.ready) begin
          load_out  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control state; a length write clears the window
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      len_r       <= LENGTH_RESET;
      sum_r       <= '0;
      pos_r       <= '0;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        len_r   <= cfg_data;
        sum_r   <= '0;
        pos_r   <= '0;
        valid_r <= '0;
      end else if (update) begin
        sum_r            <= sum_nxt;
        pos_r            <= pos_nxt;
        valid_r[pos_use] <= 1'b1;
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Window store: read the current slot each cycle, write on update
  always_ff @(posedge clk) begin
    rd_data_r <= mem[pos_use];
    if (update) begin
      mem[pos_use] <= sample_r;
    end
  end

  // Hold the taken sample and the outgoing average
  always_ff @(posedge clk) begin
    if (take) begin
      sample_r <= q_ch.sample;
    end
    if (load_out) begin
      avg_r <= SAMPLE_BITS'(div_quo);
    end
  end

  mav_div #(
    .NUM_BITS (SUM_BITS),
    .DEN_BITS (LEN_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (update),
    .dividend (sum_nxt),
    .divisor  (act_len),
    .done     (div_done),
    .quotient (div_quo)
  );

  assign out_ch.valid   = out_valid_r;
  assign out_ch.average = avg_r;

endmodule

@@ src/moving_average_filter.sv @@
`timescale 1ns / 1ps

// Channel   Dir  Payload                 Transfer
// in_ch     in   sample  [SAMPLE_BITS]   valid && ready
// out_ch    out  average [SAMPLE_BITS]   valid && ready
// cfg       in   cfg_data [5] length     cfg_we high at clock edge
//
// The back end handles each sample in order: take, window update, the
// bit-per-cycle restoring divider, and the hand-off to the output register.
// A two-entry input queue takes beats while the back end works or while a
// result waits in the output register.
// Reset and every length write clear the window, the sum and the position.
module moving_average_filter
  import mav_pkg::*;
#(
  parameter int unsigned WINDOW_MAX  = 16,
  parameter int unsigned SAMPLE_BITS = 12
) (
  input  logic                   clk,
  input  logic                   rst_n,
  mav_sample_if.sink             in_ch,
  mav_average_if.source          out_ch,
  input  logic                   cfg_we,
  input  logic [LENGTH_BITS-1:0] cfg_data
);

  mav_sample_if #(.SAMPLE_BITS(SAMPLE_BITS)) q_if ();

  mav_queue #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .q_ch  (q_if.source)
  );

  mav_back #(
    .WINDOW_MAX  (WINDOW_MAX),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .q_ch     (q_if.sink),
    .out_ch   (out_ch)
  );

endmodule
